// ----- rtl/covariance_propagate_assert.svh -----
// Assertion macros for the covariance propagation RTL.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef COVARIANCE_PROPAGATE_ASSERT_SVH
`define COVARIANCE_PROPAGATE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("covariance_propagate: implication failed");

// The condition must never hold.
`define CVP_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("covariance_propagate: forbidden condition seen");

`endif

// ----- rtl/cvp_pkg.sv -----
// Shared types and constants of the covariance propagation block.
// Used by cvp_conf and covariance_propagate; depends on nothing.
package cvp_pkg;

	typedef enum logic [1:0] {
		FN_LOAD_COV = 2'd0,
		FN_LOAD_JAC = 2'd1,
		FN_FWD      = 2'd2,
		FN_BWD      = 2'd3
	} func_t;

	localparam logic [5:0] SQ_STEPS  = 6'd24;
	localparam logic [5:0] DIV_STEPS = 6'd33;

	typedef struct packed {
		logic        done;
		logic [16:0] value;
	} conf_status_t;

endpackage

// ----- rtl/cvp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
module cvp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/cvp_conf.sv -----
// Row confidence unit: bit-serial square root followed by restoring division.
// Depends on cvp_pkg for the step counts and the status struct.
module cvp_conf import cvp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] diag,
	output conf_status_t       status
);

	typedef enum logic [2:0] {
		CF_IDLE = 3'b001,
		CF_SQRT = 3'b010,
		CF_DIV  = 3'b100
	} cf_state_t;

	cf_state_t   state_q;
	logic [5:0]  cnt_q;
	logic [47:0] x_q, r_q, bit_q;
	logic [24:0] den_q;
	logic [32:0] num_q;
	logic [25:0] rem_q;
	logic [16:0] quo_q;
	logic        done_q;

	logic [47:0] trial, x_next, r_next;
	logic [24:0] den_next;
	logic [25:0] rem_shift;
	logic        qbit;

	always_comb begin
		trial = r_q + bit_q;
		if (x_q >= trial) begin
			x_next = x_q - trial;
			r_next = (r_q >> 1) + bit_q;
		end else begin
			x_next = x_q;
			r_next = r_q >> 1;
		end
		// The root stays below 2^24, so the denominator fits 25 bits.
		den_next = 25'd65536 + r_next[24:0];
		rem_shift = {rem_q[24:0], num_q[32]};
		qbit = (rem_shift >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CF_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				CF_IDLE: begin
					if (start) begin
						state_q <= CF_SQRT;
						cnt_q <= '0;
					end
				end
				CF_SQRT: begin
					if (cnt_q == SQ_STEPS - 6'd1) begin
						state_q <= CF_DIV;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				CF_DIV: begin
					if (cnt_q == DIV_STEPS - 6'd1) begin
						state_q <= CF_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: state_q <= CF_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CF_IDLE: begin
				// A negative diagonal is clamped to zero before the root.
				x_q <= diag[31] ? 48'd0 : {1'b0, diag[30:0], 16'h0000};
				r_q <= '0;
				bit_q <= 48'h1 << 46;
			end
			CF_SQRT: begin
				x_q <= x_next;
				r_q <= r_next;
				bit_q <= bit_q >> 2;
				if (cnt_q == SQ_STEPS - 6'd1) begin
					den_q <= den_next;
					num_q <= 33'h1_0000_0000 + {9'd0, den_next[24:1]};
					rem_q <= '0;
					quo_q <= '0;
				end
			end
			CF_DIV: begin
				rem_q <= qbit ? (rem_shift - {1'b0, den_q}) : rem_shift;
				num_q <= {num_q[31:0], 1'b0};
				quo_q <= {quo_q[15:0], qbit};
			end
			default: ;
		endcase
	end

	assign status.done = done_q;
	assign status.value = quo_q;

endmodule

// ----- rtl/covariance_propagate.sv -----
// Covariance propagation block: holds P and J, runs J*P*J^T or J^T*P*J.
// Depends on cvp_pkg, cvp_ram, cvp_conf and covariance_propagate_assert.svh.
//
// Input transactions (in_valid/in_ready) carry func, row, col and value.
// A load writes one element of P or J in the cycle it is accepted and gives
// no result; a load outside the matrix is dropped. A run (forward or
// backward) streams DIM*DIM result transactions in row-major order on
// out_valid/out_ready, the final one flagged by last.
// During a run, each of the 2*DIM^3 products passes one at a time through
// the shared multiply-accumulate pipeline fed by the P, J and scratch
// memories, the root and division of each row's confidence go one bit per
// cycle, and each result passes through ST_EMIT_RD and then ST_EMIT_WAIT for
// its memory read. in_ready is high only between runs, including while the
// last result still waits in the output register. A stalled receiver holds
// the output register and pauses the run's emission. diag_noise is written
// through cfg_we/cfg_wdata.
// Reset clears P and J at once through per-entry valid bits and clears
// diag_noise directly; no clearing pass is needed.
module covariance_propagate import cvp_pkg::*; #(
	parameter int DIM = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [30:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic signed [31:0] cov_value,
	output logic [16:0]        confidence,
	output logic               saturated,
	output logic               last
);

	`include "covariance_propagate_assert.svh"

	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int CELLS = DIM * DIM;
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ACW = 65 + $clog2(DIM);
	localparam int RW = ACW - 15;
	localparam logic [IW-1:0] IDX_LAST = IW'(DIM - 1);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_A_ISSUE   = 8'b0000_0010,
		ST_A_DRAIN   = 8'b0000_0100,
		ST_B_ISSUE   = 8'b0000_1000,
		ST_B_DRAIN   = 8'b0001_0000,
		ST_CONF      = 8'b0010_0000,
		ST_EMIT_RD   = 8'b0100_0000,
		ST_EMIT_WAIT = 8'b1000_0000
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		int a;
		a = int'(r) * DIM + int'(c);
		return a[AW-1:0];
	endfunction

	state_t state_q;
	logic [30:0] noise_q;
	logic fwd_q, phase_b_q;
	logic [IW-1:0] ci_q, cj_q, ck_q, cr_q, ei_q, ej_q;
	logic [CELLS-1:0] cov_valid_q, jac_valid_q, elflag_q;
	logic [DIM-1:0] rowflag_q;
	logic signed [31:0] diag_q [DIM];
	logic [16:0] conf_q [DIM];

	// Multiply-accumulate pipeline.
	logic v_s1, first_s1, last_s1, jac_vld_s1, cov_vld_s1;
	logic [IW-1:0] i_s1, j_s1, i_s2, j_s2, i_s3, j_s3;
	logic v_s2, first_s2, last_s2, v_s3;
	logic signed [63:0] prod_s2;
	logic signed [ACW-1:0] acc_q, sum_s3;

	logic out_valid_q, out_last_q, out_sat_q;
	logic [1:0] out_row_q, out_col_q;
	logic [31:0] out_val_q;
	logic [16:0] out_conf_q;

	logic accept, issue, drained, ck_end, cj_end, ci_end, out_free, run_busy;
	logic load_cov, load_jac, load_ok;
	logic cov_we, jac_we, scr_we, cov_re;
	logic [AW-1:0] cov_waddr, jac_raddr, cov_raddr, load_addr, wr_addr, scr_raddr;
	logic [31:0] cov_wdata, cov_rdata, jac_rdata, scr_rdata;
	logic [31:0] a_s1, b_s1;
	logic signed [ACW-1:0] prod_ext, acc_next, rsum;
	logic signed [RW-1:0] rnd_v, qmax, qmin;
	logic clip, noise_en;
	logic [31:0] sat_val;
	logic conf_start;
	logic [IW-1:0] conf_row;
	conf_status_t conf_status;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign load_ok = (int'(row) < DIM) && (int'(col) < DIM);
	assign load_cov = accept && (func_t'(func) == FN_LOAD_COV) && load_ok;
	assign load_jac = accept && (func_t'(func) == FN_LOAD_JAC) && load_ok;
	assign load_addr = cell_addr(IW'(row), IW'(col));

	assign issue = (state_q == ST_A_ISSUE) || (state_q == ST_B_ISSUE);
	assign run_busy = issue || (state_q == ST_A_DRAIN) || (state_q == ST_B_DRAIN);
	assign drained = !v_s1 && !v_s2 && !v_s3;
	assign ck_end = (ck_q == IDX_LAST);
	assign cj_end = (cj_q == IDX_LAST);
	assign ci_end = (ci_q == IDX_LAST);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (!phase_b_q) begin
			jac_raddr = fwd_q ? cell_addr(ci_q, ck_q) : cell_addr(ck_q, ci_q);
		end else begin
			jac_raddr = fwd_q ? cell_addr(cj_q, ck_q) : cell_addr(ck_q, cj_q);
		end
		scr_raddr = cell_addr(ci_q, ck_q);
		cov_raddr = (state_q == ST_EMIT_RD) ? cell_addr(ei_q, ej_q) : cell_addr(ck_q, cj_q);
		cov_re = (state_q == ST_EMIT_RD) || (issue && !phase_b_q);
	end

	// Operands as they leave the memories; entries of P and J not written since reset read as zero.
	always_comb begin
		if (phase_b_q) begin
			a_s1 = scr_rdata;
			b_s1 = jac_vld_s1 ? jac_rdata : 32'd0;
		end else begin
			a_s1 = jac_vld_s1 ? jac_rdata : 32'd0;
			b_s1 = cov_vld_s1 ? cov_rdata : 32'd0;
		end
	end

	always_comb begin
		prod_ext = {{(ACW-64){prod_s2[63]}}, prod_s2};
		acc_next = first_s2 ? prod_ext : acc_q + prod_ext;
		// Round half up to Q16.16, add the noise on the forward diagonal, then saturate.
		rsum = sum_s3 + ACW'(32768);
		noise_en = fwd_q && phase_b_q && (i_s3 == j_s3);
		rnd_v = $signed({rsum[ACW-1], rsum[ACW-1:16]})
			+ $signed({{(RW-31){1'b0}}, (noise_en ? noise_q : 31'd0)});
		qmax = $signed({{(RW-32){1'b0}}, 32'h7fff_ffff});
		qmin = $signed({{(RW-32){1'b1}}, 32'h8000_0000});
		clip = 1'b0;
		sat_val = rnd_v[31:0];
		if (rnd_v > qmax) begin
			clip = 1'b1;
			sat_val = 32'h7fff_ffff;
		end else if (rnd_v < qmin) begin
			clip = 1'b1;
			sat_val = 32'h8000_0000;
		end
		wr_addr = cell_addr(i_s3, j_s3);
	end

	assign scr_we = v_s3 && !phase_b_q;
	assign cov_we = load_cov || (v_s3 && phase_b_q);
	assign cov_waddr = load_cov ? load_addr : wr_addr;
	assign cov_wdata = load_cov ? value : sat_val;
	assign jac_we = load_jac;

	assign conf_start = ((state_q == ST_B_DRAIN) && drained)
		|| ((state_q == ST_CONF) && conf_status.done && (cr_q != IDX_LAST));
	assign conf_row = (state_q == ST_CONF) ? cr_q + IW'(1) : '0;

	cvp_ram #(.WIDTH(32), .DEPTH(CELLS)) u_cov_ram (
		.clk(clk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
		.re(cov_re), .raddr(cov_raddr), .rdata(cov_rdata)
	);

	cvp_ram #(.WIDTH(32), .DEPTH(CELLS)) u_jac_ram (
		.clk(clk), .we(jac_we), .waddr(load_addr), .wdata(value),
		.re(issue), .raddr(jac_raddr), .rdata(jac_rdata)
	);

	cvp_ram #(.WIDTH(32), .DEPTH(CELLS)) u_scr_ram (
		.clk(clk), .we(scr_we), .waddr(wr_addr), .wdata(sat_val),
		.re(issue && phase_b_q), .raddr(scr_raddr), .rdata(scr_rdata)
	);

	cvp_conf u_conf (
		.clk(clk), .arst_n(arst_n), .start(conf_start),
		.diag(diag_q[conf_row]), .status(conf_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			noise_q <= '0;
			fwd_q <= 1'b0;
			phase_b_q <= 1'b0;
			ci_q <= '0;
			cj_q <= '0;
			ck_q <= '0;
			cr_q <= '0;
			ei_q <= '0;
			ej_q <= '0;
			cov_valid_q <= '0;
			jac_valid_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				noise_q <= cfg_wdata;
			end
			if (cov_we) begin
				cov_valid_q[cov_waddr] <= 1'b1;
			end
			if (jac_we) begin
				jac_valid_q[load_addr] <= 1'b1;
			end
			if (out_valid_q && out_ready && !((state_q == ST_EMIT_WAIT) && out_free)) begin
				out_valid_q <= 1'b0;
			end

			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;

			case (state_q)
				ST_IDLE: begin
					if (accept && (func_t'(func) == FN_FWD || func_t'(func) == FN_BWD)) begin
						fwd_q <= (func_t'(func) == FN_FWD);
						phase_b_q <= 1'b0;
						ci_q <= '0;
						cj_q <= '0;
						ck_q <= '0;
						state_q <= ST_A_ISSUE;
					end
				end
				ST_A_ISSUE, ST_B_ISSUE: begin
					ck_q <= ck_end ? '0 : ck_q + IW'(1);
					if (ck_end) begin
						cj_q <= cj_end ? '0 : cj_q + IW'(1);
						if (cj_end) begin
							ci_q <= ci_end ? '0 : ci_q + IW'(1);
							if (ci_end) begin
								state_q <= (state_q == ST_A_ISSUE) ? ST_A_DRAIN : ST_B_DRAIN;
							end
						end
					end
				end
				ST_A_DRAIN: begin
					// The scratch rows must all be written before the second product reads them.
					if (drained) begin
						phase_b_q <= 1'b1;
						state_q <= ST_B_ISSUE;
					end
				end
				ST_B_DRAIN: begin
					if (drained) begin
						cr_q <= '0;
						state_q <= ST_CONF;
					end
				end
				ST_CONF: begin
					if (conf_status.done) begin
						if (cr_q == IDX_LAST) begin
							ei_q <= '0;
							ej_q <= '0;
							state_q <= ST_EMIT_RD;
						end else begin
							cr_q <= cr_q + IW'(1);
						end
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ej_q <= (ej_q == IDX_LAST) ? '0 : ej_q + IW'(1);
						if (ej_q == IDX_LAST) begin
							ei_q <= ei_q + IW'(1);
						end
						if ((ej_q == IDX_LAST) && (ei_q == IDX_LAST)) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload and per-run bookkeeping.
	always_ff @(posedge clk) begin
		i_s1 <= ci_q;
		j_s1 <= cj_q;
		first_s1 <= (ck_q == '0);
		last_s1 <= ck_end;
		jac_vld_s1 <= jac_valid_q[jac_raddr];
		cov_vld_s1 <= cov_valid_q[cov_raddr];

		prod_s2 <= $signed(a_s1) * $signed(b_s1);
		i_s2 <= i_s1;
		j_s2 <= j_s1;
		first_s2 <= first_s1;
		last_s2 <= last_s1;

		if (v_s2) begin
			acc_q <= acc_next;
			if (last_s2) begin
				sum_s3 <= acc_next;
				i_s3 <= i_s2;
				j_s3 <= j_s2;
			end
		end

		if (state_q == ST_IDLE) begin
			rowflag_q <= '0;
		end else if (scr_we && clip) begin
			rowflag_q[i_s3] <= 1'b1;
		end

		if (v_s3 && phase_b_q) begin
			elflag_q[wr_addr] <= clip || rowflag_q[i_s3];
			if (i_s3 == j_s3) begin
				diag_q[i_s3] <= sat_val;
			end
		end

		if ((state_q == ST_CONF) && conf_status.done) begin
			conf_q[cr_q] <= conf_status.value;
		end

		if ((state_q == ST_EMIT_WAIT) && out_free) begin
			out_row_q <= 2'(ei_q);
			out_col_q <= 2'(ej_q);
			out_val_q <= cov_valid_q[cell_addr(ei_q, ej_q)] ? cov_rdata : 32'd0;
			out_conf_q <= conf_q[ei_q];
			out_sat_q <= elflag_q[cell_addr(ei_q, ej_q)];
			out_last_q <= (ej_q == IDX_LAST) && (ei_q == IDX_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign cov_value = out_val_q;
	assign confidence = out_conf_q;
	assign saturated = out_sat_q;
	assign last = out_last_q;

	`CVP_ASSERT_IMPL(a_pipe_in_run, v_s1, run_busy)
	`CVP_ASSERT_IMPL(a_sum_follows_product, v_s3, $past(v_s2) && $past(last_s2))
	`CVP_ASSERT_NEVER(a_conf_done_in_conf, conf_status.done && (state_q != ST_CONF))

endmodule
